FILE: hw/rtl/tsba_pkg.sv
// shared types and codes for the texture slot batch assigner
package tsba_pkg;

    localparam logic [1:0] ACT_QUAD  = 2'd0;
    localparam logic [1:0] ACT_BEGIN = 2'd1;
    localparam logic [1:0] ACT_END   = 2'd2;

    localparam int IDX_PER_QUAD = 6;

    typedef struct packed {
        logic [3:0]  slot_index;
        logic        flushed;
        logic [12:0] flush_index_count;
        logic [4:0]  flush_slot_count;
        logic [31:0] draw_call_count;
    } tsba_result_t;

endpackage

FILE: hw/rtl/tsba_slot_table.sv
// slot handle table with parallel compare and lowest-match select
module tsba_slot_table #(
    parameter int SLOT_COUNT = 16,
    parameter int HANDLE_W   = 32,
    parameter int SLOT_W     = 4,
    parameter int USED_W     = 5
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [SLOT_W-1:0]   wr_addr,
    input  logic [HANDLE_W-1:0] wr_data,
    input  logic [HANDLE_W-1:0] lookup,
    input  logic [USED_W-1:0]   slots_used,
    output logic                hit,
    output logic [SLOT_W-1:0]   hit_slot
);

    logic [HANDLE_W-1:0] entry_reg [1:SLOT_COUNT-1];
    logic [SLOT_COUNT-1:1] match;

    always_ff @(posedge aclk) begin
        for (int i = 1; i < SLOT_COUNT; i++) begin
            if (wr_en && (wr_addr == SLOT_W'(i))) begin
                entry_reg[i] <= wr_data;
            end
        end
    end

    // only slots below the fill level hold live handles
    always_comb begin
        for (int i = 1; i < SLOT_COUNT; i++) begin
            match[i] = (USED_W'(i) < slots_used) && (entry_reg[i] == lookup);
        end
    end

    always_comb begin
        hit      = |match;
        hit_slot = '0;
        for (int i = SLOT_COUNT - 1; i >= 1; i--) begin
            if (match[i]) begin
                hit_slot = SLOT_W'(i);
            end
        end
    end

endmodule

FILE: hw/rtl/tsba_out_stage.sv
// result register with valid/ready toward the consumer
module tsba_out_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  tsba_pkg::tsba_result_t res_in,
    output logic                  can_push,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tsba_pkg::tsba_result_t res_out
);

    import tsba_pkg::*;

    logic         valid_reg;
    tsba_result_t res_reg;

    assign can_push = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign res_out  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_push) begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && can_push) begin
            res_reg <= res_in;
        end
    end

endmodule

FILE: hw/rtl/texture_slot_batch_assigner.sv
// top level: input register, batch state and result register
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_action, s_texture_handle
//  m_      | out       | m_valid / m_ready  | slot index, flush report, draw call count
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_white_handle
//
// one item per cycle while the result is not stalled; an item is accepted into the
// input register, then moves into the result register. the batch state updates in the
// same cycle the item moves into the result register, so the next item follows directly.
// reset empties both registers and opens an empty batch; the slot table is
// not cleared. a stalled result holds the input register, which then drops s_ready.
module texture_slot_batch_assigner #(
    parameter int MAX_QUADS_PER_BATCH = 1024,
    parameter int SLOT_COUNT          = 16,
    parameter int HANDLE_BITS         = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_white_handle,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [31:0] s_texture_handle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_slot_index,
    output logic        m_flushed,
    output logic [12:0] m_flush_index_count,
    output logic [4:0]  m_flush_slot_count,
    output logic [31:0] m_draw_call_count
);

    import tsba_pkg::*;

    localparam int HandleW = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
    localparam int SlotW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int UsedW   = $clog2(SLOT_COUNT + 1);
    localparam int QuadW   = $clog2(MAX_QUADS_PER_BATCH + 1);

    logic [31:0]        white_reg;
    logic               in_valid_reg;
    logic [1:0]         in_action_reg;
    logic [HandleW-1:0] in_handle_reg;
    logic [QuadW-1:0]   quads_reg, quads_next;
    logic [UsedW-1:0]   slots_used_reg, slots_used_next;
    logic [31:0]        batches_reg, batches_next;

    logic               can_push, fire;
    logic               is_quad, is_begin, is_end, non_empty;
    logic               overflow, white_hit, tbl_hit, reuse, need_new, full;
    logic [SlotW-1:0]   tbl_slot, slot;
    logic [UsedW-1:0]   cur_slots, alloc_slot;
    logic               flushed;
    logic [31:0]        slot_wide, idx_wide, used_wide;
    tsba_result_t       res_next, res_out;

    assign cfg_ready = 1'b1;
    assign s_ready   = !in_valid_reg || can_push;
    assign fire      = in_valid_reg && can_push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            white_reg <= '0;
        end else if (cfg_valid) begin
            white_reg <= cfg_white_handle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_action_reg <= s_action;
            in_handle_reg <= s_texture_handle[HandleW-1:0];
        end
    end

    tsba_slot_table #(
        .SLOT_COUNT (SLOT_COUNT),
        .HANDLE_W   (HandleW),
        .SLOT_W     (SlotW),
        .USED_W     (UsedW)
    ) u_table (
        .aclk       (aclk),
        .wr_en      (fire && need_new),
        .wr_addr    (alloc_slot[SlotW-1:0]),
        .wr_data    (in_handle_reg),
        .lookup     (in_handle_reg),
        .slots_used (slots_used_reg),
        .hit        (tbl_hit),
        .hit_slot   (tbl_slot)
    );

    always_comb begin
        is_quad   = (in_action_reg == ACT_QUAD);
        is_begin  = (in_action_reg == ACT_BEGIN);
        is_end    = (in_action_reg == ACT_END);
        non_empty = (quads_reg != '0);

        // a full batch is closed before the quad is placed
        overflow  = is_quad && (quads_reg == QuadW'(MAX_QUADS_PER_BATCH));
        cur_slots = overflow ? UsedW'(1) : slots_used_reg;
        white_hit = (in_handle_reg == white_reg[HandleW-1:0]);
        reuse     = tbl_hit && !overflow;
        need_new  = is_quad && !white_hit && !reuse;
        full      = need_new && !overflow && (slots_used_reg >= UsedW'(SLOT_COUNT));
        alloc_slot = full ? UsedW'(1) : cur_slots;

        if (white_hit) begin
            slot = '0;
        end else if (reuse) begin
            slot = tbl_slot;
        end else begin
            slot = alloc_slot[SlotW-1:0];
        end

        flushed = non_empty && (overflow || full || is_end);

        quads_next      = quads_reg;
        slots_used_next = slots_used_reg;
        if (is_quad) begin
            quads_next      = ((overflow || full) ? '0 : quads_reg) + QuadW'(1);
            slots_used_next = need_new ? alloc_slot + UsedW'(1) : cur_slots;
        end else if (is_begin) begin
            quads_next      = '0;
            slots_used_next = UsedW'(1);
        end
        batches_next = batches_reg + (flushed ? 32'd1 : 32'd0);

        slot_wide = 32'(slot);
        idx_wide  = 32'(quads_reg) * 32'(IDX_PER_QUAD);
        used_wide = 32'(slots_used_reg);

        res_next.slot_index        = is_quad ? slot_wide[3:0] : 4'd0;
        res_next.flushed           = flushed;
        res_next.flush_index_count = flushed ? idx_wide[12:0] : 13'd0;
        res_next.flush_slot_count  = flushed ? used_wide[4:0] : 5'd0;
        res_next.draw_call_count   = batches_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quads_reg      <= '0;
            slots_used_reg <= UsedW'(1);
            batches_reg    <= '0;
        end else if (fire) begin
            quads_reg      <= quads_next;
            slots_used_reg <= slots_used_next;
            batches_reg    <= batches_next;
        end
    end

    tsba_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (in_valid_reg),
        .res_in   (res_next),
        .can_push (can_push),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .res_out  (res_out)
    );

    assign m_slot_index        = res_out.slot_index;
    assign m_flushed           = res_out.flushed;
    assign m_flush_index_count = res_out.flush_index_count;
    assign m_flush_slot_count  = res_out.flush_slot_count;
    assign m_draw_call_count   = res_out.draw_call_count;

endmodule
